### rtl/hmap_pkg.sv
// Shared types and constants for the memory access heatmap.
// Depends on nothing; imported by every other file of the block.
package hmap_pkg;

	localparam int CNT_W = 16;
	localparam int WORD_W = 2 * CNT_W;
	localparam int N_TABLES = 4;
	localparam int USER_W = 16;

	typedef logic [CNT_W-1:0] count_t;
	typedef logic [WORD_W-1:0] word_t;
	typedef logic [USER_W-1:0] user_t;

	localparam count_t CNT_MAX = '1;
	localparam user_t USER_MAX = '1;

	// Command codes; code 7 is unused and ignored
	typedef enum logic [2:0] {
		CMD_TRACK       = 3'd0,
		CMD_QUERY_COUNT = 3'd1,
		CMD_QUERY_MAX   = 3'd2,
		CMD_DECAY       = 3'd3,
		CMD_ACQUIRE     = 3'd4,
		CMD_RELEASE     = 3'd5,
		CMD_RESET       = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		SW_IDLE,
		SW_CLEAR,
		SW_DECAY
	} sweep_state_t;

	// Sweep engine to datapath control
	typedef struct packed {
		logic busy;
		logic rd_en;
		logic wr_en;
		logic clear;
	} sweep_ctrl_t;

	// Memory word holds {write count, read count}
	function automatic word_t halve_word(input word_t w);
		count_t hi;
		count_t lo;
		hi = w[WORD_W-1:CNT_W] >> 1;
		lo = w[CNT_W-1:0] >> 1;
		return {hi, lo};
	endfunction

endpackage

### rtl/hmap_ram.sv
// Simple dual-port synchronous RAM, registered read, with
// write-to-read bypass for same-address collisions. Uses hmap_pkg.
module hmap_ram #(
	parameter int AW = 16
) (
	input  logic                clk,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output hmap_pkg::word_t     rd_data,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  hmap_pkg::word_t     wr_data
);
	import hmap_pkg::*;

	word_t mem [2**AW];
	word_t rdata_q;
	word_t byp_data_q;
	logic  byp_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; a write to the same address in the same cycle is forwarded
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q    <= mem[rd_addr];
			byp_q      <= wr_en && (wr_addr == rd_addr);
			byp_data_q <= wr_data;
		end
	end

	assign rd_data = byp_q ? byp_data_q : rdata_q;

endmodule

### rtl/hmap_sweep.sv
// Sweep engine: walks every table entry to clear it or halve it.
// Uses hmap_pkg; drives the RAM ports of the top level during a sweep.
module hmap_sweep #(
	parameter int SB = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start_clear,
	input  logic                   start_decay,
	output hmap_pkg::sweep_ctrl_t  ctrl,
	output logic [SB-1:0]          rd_addr,
	output logic [SB-1:0]          wr_addr
);
	import hmap_pkg::*;

	sweep_state_t state_q, state_nxt;
	logic [SB:0]   cnt_q;
	logic          pend_q;
	logic [SB-1:0] pend_addr_q;
	logic          cnt_done;

	assign cnt_done = cnt_q[SB];

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			SW_IDLE: begin
				if (start_clear) begin
					state_nxt = SW_CLEAR;
				end else if (start_decay) begin
					state_nxt = SW_DECAY;
				end
			end
			SW_CLEAR: begin
				if (cnt_done) begin
					state_nxt = SW_IDLE;
				end
			end
			SW_DECAY: begin
				// last halved word is written in this cycle
				if (cnt_done && pend_q) begin
					state_nxt = SW_IDLE;
				end
			end
			default: state_nxt = SW_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		ctrl = '0;
		case (state_q)
			SW_CLEAR: begin
				ctrl.busy  = 1'b1;
				ctrl.clear = 1'b1;
				ctrl.wr_en = !cnt_done;
			end
			SW_DECAY: begin
				ctrl.busy  = 1'b1;
				ctrl.rd_en = !cnt_done;
				ctrl.wr_en = pend_q;
			end
			default: ctrl = '0;
		endcase
	end

	assign rd_addr = cnt_q[SB-1:0];
	assign wr_addr = (state_q == SW_DECAY) ? pend_addr_q : cnt_q[SB-1:0];

	// State, entry counter and pending write-back of a decay step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SW_CLEAR;
			cnt_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == SW_IDLE) begin
				cnt_q <= '0;
			end else if (!cnt_done) begin
				cnt_q <= cnt_q + 1'b1;
			end
			pend_q <= ctrl.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		pend_addr_q <= cnt_q[SB-1:0];
	end

`ifndef ASSERT_OFF
	a_no_start_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.busy |-> !(start_clear || start_decay))
		else $error("sweep requested while a sweep runs");
	a_decay_wb_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.rd_en |=> (ctrl.wr_en && wr_addr == $past(rd_addr)))
		else $error("decay read not written back next cycle");
	a_clear_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clear |-> !ctrl.rd_en)
		else $error("clear sweep issued a read");
`endif

endmodule

### rtl/memory_access_heatmap_top.sv
// Memory access heatmap top level: command pipeline, user count, maxima.
// Depends on hmap_pkg, hmap_ram and hmap_sweep.
//
//  channel   | handshake         | payload
//  ----------+-------------------+-----------------------------------------
//  command   | start / busy      | command, space, write_tbl, address
//  result    | done (strobe)     | value, active
//
// Track and queries: one transaction per cycle while busy is low; the result
// strobe follows acceptance through valid_s1 and the done register. The wide
// or narrow RAM, as space selects, is read on acceptance and, for a track with
// a user, written back next cycle; the RAM bypass covers back-to-back hits.
// Decay holds busy while the sweep halves every entry, clearing (reset
// command, last release) and the post-arst_n pass while all are zeroed.
// The receiver cannot stall: done is high for exactly one cycle per result.
module memory_access_heatmap_top #(
	parameter int WIDE_ADDR_BITS   = 16,
	parameter int NARROW_ADDR_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  command,
	input  logic        space,
	input  logic        write_tbl,
	input  logic [15:0] address,
	output logic        done,
	output logic [15:0] value,
	output logic        active
);
	import hmap_pkg::*;

	localparam int WB = WIDE_ADDR_BITS;
	localparam int NB = NARROW_ADDR_BITS;
	localparam int SB = (WB > NB) ? WB : NB;

	// Sweep engine
	sweep_ctrl_t   sw;
	logic [SB-1:0] sw_rd_addr;
	logic [SB-1:0] sw_wr_addr;
	logic          start_clear;
	logic          start_decay;

	hmap_sweep #(.SB(SB)) u_sweep (
		.clk         (clk),
		.arst_n      (arst_n),
		.start_clear (start_clear),
		.start_decay (start_decay),
		.ctrl        (sw),
		.rd_addr     (sw_rd_addr),
		.wr_addr     (sw_wr_addr)
	);

	// Command stage registers
	logic          valid_s1;
	cmd_t          cmd_s1;
	logic          space_s1;
	logic          wr_s1;
	logic [WB-1:0] waddr_s1;
	logic [NB-1:0] naddr_s1;
	logic          accept;

	assign accept = start && !busy;
	assign busy   = sw.busy || (valid_s1 &&
		(cmd_s1 == CMD_DECAY || cmd_s1 == CMD_RELEASE || cmd_s1 == CMD_RESET));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= cmd_t'(command);
			space_s1 <= space;
			wr_s1    <= write_tbl;
			waddr_s1 <= WB'(address);
			naddr_s1 <= NB'(address);
		end
	end

	// RAM ports
	word_t         w_rdata, n_rdata;
	logic          w_rd_en, n_rd_en, w_wr_en, n_wr_en;
	logic [WB-1:0] w_rd_addr, w_wr_addr;
	logic [NB-1:0] n_rd_addr, n_wr_addr;
	word_t         w_wr_data, n_wr_data;
	word_t         track_word;
	logic          track_do;
	logic          w_rd_in, w_wr_in, n_rd_in, n_wr_in;

	// sweep addresses beyond a table's depth are skipped
	assign w_rd_in = (sw_rd_addr >> WB) == '0;
	assign w_wr_in = (sw_wr_addr >> WB) == '0;
	assign n_rd_in = (sw_rd_addr >> NB) == '0;
	assign n_wr_in = (sw_wr_addr >> NB) == '0;

	always_comb begin
		if (sw.busy) begin
			w_rd_en   = sw.rd_en && w_rd_in;
			n_rd_en   = sw.rd_en && n_rd_in;
			w_rd_addr = sw_rd_addr[WB-1:0];
			n_rd_addr = sw_rd_addr[NB-1:0];
			w_wr_en   = sw.wr_en && w_wr_in;
			n_wr_en   = sw.wr_en && n_wr_in;
			w_wr_addr = sw_wr_addr[WB-1:0];
			n_wr_addr = sw_wr_addr[NB-1:0];
			w_wr_data = sw.clear ? '0 : halve_word(w_rdata);
			n_wr_data = sw.clear ? '0 : halve_word(n_rdata);
		end else begin
			w_rd_en   = accept && !space;
			n_rd_en   = accept && space;
			w_rd_addr = WB'(address);
			n_rd_addr = NB'(address);
			w_wr_en   = track_do && !space_s1;
			n_wr_en   = track_do && space_s1;
			w_wr_addr = waddr_s1;
			n_wr_addr = naddr_s1;
			w_wr_data = track_word;
			n_wr_data = track_word;
		end
	end

	hmap_ram #(.AW(WB)) u_wide_ram (
		.clk     (clk),
		.rd_en   (w_rd_en),
		.rd_addr (w_rd_addr),
		.rd_data (w_rdata),
		.wr_en   (w_wr_en),
		.wr_addr (w_wr_addr),
		.wr_data (w_wr_data)
	);

	hmap_ram #(.AW(NB)) u_narrow_ram (
		.clk     (clk),
		.rd_en   (n_rd_en),
		.rd_addr (n_rd_addr),
		.rd_data (n_rdata),
		.wr_en   (n_wr_en),
		.wr_addr (n_wr_addr),
		.wr_data (n_wr_data)
	);

	// Command execution
	user_t        user_q, user_nxt;
	count_t       max_q [N_TABLES];
	count_t       max_nxt [N_TABLES];
	logic [1:0]   sel;
	word_t        word_s1;
	count_t       cnt_s1, cnt_inc;
	count_t       value_nxt;
	logic         user_on;
	logic         clear_all;

	assign sel      = {space_s1, wr_s1};
	assign word_s1  = space_s1 ? n_rdata : w_rdata;
	assign cnt_s1   = wr_s1 ? word_s1[WORD_W-1:CNT_W] : word_s1[CNT_W-1:0];
	assign cnt_inc  = (cnt_s1 == CNT_MAX) ? cnt_s1 : cnt_s1 + 1'b1;
	assign user_on  = user_q != '0;
	assign track_do = valid_s1 && cmd_s1 == CMD_TRACK && user_on;
	assign track_word = wr_s1 ? {cnt_inc, word_s1[CNT_W-1:0]}
	                          : {word_s1[WORD_W-1:CNT_W], cnt_inc};

	always_comb begin
		user_nxt    = user_q;
		value_nxt   = '0;
		clear_all   = 1'b0;
		start_decay = 1'b0;
		for (int i = 0; i < N_TABLES; i++) begin
			max_nxt[i] = max_q[i];
		end
		if (valid_s1) begin
			case (cmd_s1)
				CMD_TRACK: begin
					if (user_on && cnt_inc > max_q[sel]) begin
						max_nxt[sel] = cnt_inc;
					end
				end
				CMD_QUERY_COUNT: value_nxt = cnt_s1;
				CMD_QUERY_MAX:   value_nxt = max_q[sel];
				CMD_DECAY: begin
					// halving is monotone, so each maximum simply halves
					if (user_on) begin
						start_decay = 1'b1;
						for (int i = 0; i < N_TABLES; i++) begin
							max_nxt[i] = max_q[i] >> 1;
						end
					end
				end
				CMD_ACQUIRE: begin
					if (user_q != USER_MAX) begin
						user_nxt = user_q + 1'b1;
					end
				end
				CMD_RELEASE: begin
					if (user_on) begin
						user_nxt  = user_q - 1'b1;
						clear_all = (user_q == user_t'(1));
					end
				end
				CMD_RESET: clear_all = 1'b1;
				default: ;
			endcase
		end
		if (clear_all) begin
			for (int i = 0; i < N_TABLES; i++) begin
				max_nxt[i] = '0;
			end
		end
	end

	assign start_clear = clear_all;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_q <= '0;
			done   <= 1'b0;
			for (int i = 0; i < N_TABLES; i++) begin
				max_q[i] <= '0;
			end
		end else begin
			user_q <= user_nxt;
			done   <= valid_s1;
			for (int i = 0; i < N_TABLES; i++) begin
				max_q[i] <= max_nxt[i];
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			value  <= value_nxt;
			active <= user_nxt != '0;
		end
	end

`ifndef ASSERT_OFF
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done)
		else $error("no result for an accepted transaction");
	a_no_track_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sw.busy |-> !(valid_s1 && cmd_s1 == CMD_TRACK))
		else $error("track write-back collides with a sweep");
	a_active_matches: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (active == (user_q != '0)))
		else $error("active flag disagrees with user count");
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sw.busy |-> !accept)
		else $error("transaction accepted during a sweep");
`endif

endmodule
